// File: design/jse_pkg.sv
// Shared types, character codes and helper functions for the JSON string escaper.
package jse_pkg;

  // Default depth of the queue between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 4;

  // Longest run of output bytes that one input item can cause.
  localparam int RUN_MAX = 8;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);
  localparam int STEP_W  = $clog2(RUN_MAX);

  // Character codes.
  localparam logic [7:0] CHR_QUOTE   = 8'h22;
  localparam logic [7:0] CHR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_BS      = 8'h08;
  localparam logic [7:0] CHR_FF      = 8'h0C;
  localparam logic [7:0] CHR_LOWER_N = 8'h6E;
  localparam logic [7:0] CHR_LOWER_R = 8'h72;
  localparam logic [7:0] CHR_LOWER_T = 8'h74;
  localparam logic [7:0] CHR_LOWER_B = 8'h62;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;
  localparam logic [7:0] CHR_LOWER_U = 8'h75;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;

  // Escape class of one input item.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNICODE
  } char_kind_t;

  // Classified item as it travels through the queue. For a short escape,
  // data holds the character that follows the backslash.
  typedef struct packed {
    char_kind_t kind;
    logic [7:0] data;
    logic       first;
    logic       last;
  } esc_desc_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] wide;
    wide = {4'b0000, v};
    if (v < 4'd10) begin
      return CHR_ZERO + wide;
    end
    return CHR_LOWER_A + wide - 8'd10;
  endfunction

  // Number of bytes that the character part of an item produces.
  function automatic logic [2:0] char_len(input char_kind_t kind);
    logic [2:0] len;
    unique case (kind)
      KIND_NONE:    len = 3'd0;
      KIND_PLAIN:   len = 3'd1;
      KIND_SHORT:   len = 3'd2;
      KIND_UNICODE: len = 3'd6;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/jse_front.sv
// Input side: accepts items and classifies each byte by its escape form.
module jse_front (
  input  logic                push,
  input  logic                q_full,
  input  logic [7:0]          char_byte,
  input  logic                has_char,
  input  logic                is_first,
  input  logic                is_last,
  output logic                q_wr,
  output jse_pkg::esc_desc_t  q_desc
);

  assign q_wr = push & ~q_full;

  always_comb begin
    q_desc.first = is_first;
    q_desc.last  = is_last;
    q_desc.data  = char_byte;
    q_desc.kind  = jse_pkg::KIND_PLAIN;
    if (!has_char) begin
      q_desc.kind = jse_pkg::KIND_NONE;
    end else begin
      unique case (char_byte) inside
        jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
        end
        jse_pkg::CHR_LF: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
          q_desc.data = jse_pkg::CHR_LOWER_N;
        end
        jse_pkg::CHR_CR: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
          q_desc.data = jse_pkg::CHR_LOWER_R;
        end
        jse_pkg::CHR_TAB: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
          q_desc.data = jse_pkg::CHR_LOWER_T;
        end
        jse_pkg::CHR_BS: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
          q_desc.data = jse_pkg::CHR_LOWER_B;
        end
        jse_pkg::CHR_FF: begin
          q_desc.kind = jse_pkg::KIND_SHORT;
          q_desc.data = jse_pkg::CHR_LOWER_F;
        end
        default: begin
          if (char_byte < jse_pkg::CTRL_LIMIT) begin
            q_desc.kind = jse_pkg::KIND_UNICODE;
          end else begin
            q_desc.kind = jse_pkg::KIND_PLAIN;
          end
        end
      endcase
    end
  end

endmodule

// File: design/jse_queue.sv
// Short queue of classified items between the classifier and the serializer.
module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  jse_pkg::esc_desc_t  wr_desc,
  input  logic                rd,
  output jse_pkg::esc_desc_t  rd_desc,
  output logic                valid,
  output logic                full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  jse_pkg::esc_desc_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_rd;

  assign valid   = (count != '0);
  assign full    = (count == CNT_DEPTH);
  assign rd_desc = entries[rd_ptr];
  assign do_rd   = rd & valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("queue written while full");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone write");

endmodule

// File: design/jse_back.sv
// Output side: walks the byte run of each queued item into the result register.
module jse_back (
  input  logic                clk,
  input  logic                rst,
  input  jse_pkg::esc_desc_t  q_desc,
  input  logic                q_valid,
  output logic                q_rd,
  input  logic                pop,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);

  logic [jse_pkg::STEP_W-1:0] step;
  logic [jse_pkg::STEP_W-1:0] step_next;
  logic [jse_pkg::RUN_W-1:0]  run_len;
  logic [jse_pkg::RUN_W-1:0]  char_idx;
  logic [2:0]                 clen;
  logic [2:0]                 pos;
  logic [7:0]                 char_out;
  logic [7:0]                 byte_next;
  logic                       at_end;
  logic                       advance;
  logic                       emit;

  assign clen     = jse_pkg::char_len(q_desc.kind);
  assign run_len  = {3'b000, q_desc.first} + {1'b0, clen} + {3'b000, q_desc.last};
  assign char_idx = {1'b0, step} - {3'b000, q_desc.first};
  assign pos      = char_idx[2:0];
  assign at_end   = (run_len == '0) || ({1'b0, step} == run_len - 1'b1);
  assign advance  = q_valid && (!out_valid || pop);
  assign emit     = advance && (run_len != '0);
  assign q_rd     = advance && at_end;

  always_comb begin
    char_out = q_desc.data;
    case (q_desc.kind)
      jse_pkg::KIND_SHORT: begin
        if (pos == 3'd0) begin
          char_out = jse_pkg::CHR_BSLASH;
        end
      end
      jse_pkg::KIND_UNICODE: begin
        case (pos)
          3'd0:    char_out = jse_pkg::CHR_BSLASH;
          3'd1:    char_out = jse_pkg::CHR_LOWER_U;
          3'd2:    char_out = jse_pkg::CHR_ZERO;
          3'd3:    char_out = jse_pkg::CHR_ZERO;
          3'd4:    char_out = jse_pkg::hex_digit(q_desc.data[7:4]);
          default: char_out = jse_pkg::hex_digit(q_desc.data[3:0]);
        endcase
      end
      default: char_out = q_desc.data;
    endcase
  end

  always_comb begin
    if (q_desc.first && step == '0) begin
      byte_next = jse_pkg::CHR_QUOTE;
    end else if (char_idx < {1'b0, clen}) begin
      byte_next = char_out;
    end else begin
      byte_next = jse_pkg::CHR_QUOTE;
    end
  end

  always_comb begin
    step_next = step;
    if (advance) begin
      step_next = at_end ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_next;
      last_of_run <= at_end;
    end
  end

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> step == '0)
    else $error("run position left nonzero with no queued item");

  a_step_in_run: assert property (@(posedge clk) disable iff (rst)
    (q_valid && run_len != '0) |-> {1'b0, step} < run_len)
    else $error("run position past the end of the run");

endmodule

// File: design/json_string_escaper.sv
// Top level of the JSON string escaper: classifier, item queue and byte serializer.
//
// Usage. An input transfer (push high, full low at a rising edge) carries one
// byte of a text string and three flags: has_char marks the byte as part of the
// string, is_first asks for an opening double quote before it and is_last for a
// closing quote after it. Each item gives a run of zero to eight output bytes:
// opening quote, escaped byte (one, two or six bytes), closing quote, with
// last_of_run set on the final byte. A result transfer needs pop high, empty low.
//
// Timing. The classifier writes each accepted item into a short queue at the
// transfer edge. The serializer takes the queue head and, while the result is
// empty or popped, loads one output byte per cycle into the result register;
// the first byte of a run passes the queue entry and the result register on
// its way out. A run holds the serializer until its last byte; an item with
// no output bytes only leaves the queue. Plain characters stream at one item
// per cycle while pop is high, and the queue takes up escape runs until full.
//
// Reset (rst, synchronous) empties the queue and the result register. When
// the receiver holds pop low the result byte stays in place, the serializer
// waits, and new items collect in the queue until it is full.
module json_string_escaper #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       has_char,
  input  logic       is_first,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  jse_pkg::esc_desc_t wr_desc;
  jse_pkg::esc_desc_t head_desc;
  logic               q_wr;
  logic               q_rd;
  logic               q_valid;
  logic               q_full;
  logic               out_valid;

  // Input side: classification happens on the way into the queue.
  jse_front u_front (
    .push      (push),
    .q_full    (q_full),
    .char_byte (char_byte),
    .has_char  (has_char),
    .is_first  (is_first),
    .is_last   (is_last),
    .q_wr      (q_wr),
    .q_desc    (wr_desc)
  );

  // Decoupling queue; full on the input port is the queue being full.
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_desc (wr_desc),
    .rd      (q_rd),
    .rd_desc (head_desc),
    .valid   (q_valid),
    .full    (q_full)
  );

  // Output side: one escaped byte per cycle into the result register while it is empty or popped.
  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_desc      (head_desc),
    .q_valid     (q_valid),
    .q_rd        (q_rd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  assign full  = q_full;
  assign empty = ~out_valid;

endmodule
